FILE: design/qrs_pkg.sv
// shared types and constants for the quadratic root solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  localparam int SQ_STAGES = 17;
  localparam int DV_STAGES = 33;

  localparam logic [1:0] ST_NOT_QUAD = 2'd0;
  localparam logic [1:0] ST_NO_ROOTS = 2'd1;
  localparam logic [1:0] ST_ONE_ROOT = 2'd2;
  localparam logic [1:0] ST_TWO_ROOTS = 2'd3;

  localparam logic signed [31:0] ROOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ROOT_MIN = 32'sh8000_0000;

  // square root phase request
  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic [33:0]        delta;
    logic signed [17:0] neg_b;
    logic               den_neg;
    logic [16:0]        den_mag;
    logic [33:0]        rad;
    logic [19:0]        rem;
    logic [16:0]        root;
  } sq_t;

  // one divider lane
  typedef struct packed {
    logic        neg;
    logic [32:0] dvd;
    logic [16:0] rem;
    logic [32:0] quo;
  } lane_t;

  // division phase request
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [33:0] delta;
    logic        den_neg;
    logic [16:0] den_mag;
    lane_t       p;
    lane_t       m;
  } dv_t;

endpackage

`default_nettype wire

FILE: design/quadratic_root_solver.sv
// top level of the quadratic root solver: products, discriminant, root and divide pipeline
// depends on qrs_pkg, qrs_sqrt_stage, qrs_div_stage
//
// Usage: each input request carries signed Q8.8 coefficients coef_a, coef_b,
// coef_c. A request is taken on a rising edge with valid high and stall low.
// Each request gives exactly one result request: status, the Q16.16
// discriminant b*b-4ac, the two Q16.16 roots (-b +/- isqrt(delta))/(2a)
// truncated toward zero and saturated, and an overflow flag.
// The pipeline has one product stage, one discriminant stage, 17
// square root stages (two radicand bits each), one numerator stage, 33
// divide stages (one quotient bit each, both roots in parallel) and the
// output register. It takes one request per cycle while in_stall is low.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated. While the output register
// is empty, out_stall holds nothing back and requests keep entering.
// Synchronous reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [15:0]  coef_a,
  input  wire signed [15:0]  coef_b,
  input  wire signed [15:0]  coef_c,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         status,
  output logic signed [33:0] discriminant,
  output logic signed [31:0] root_plus,
  output logic signed [31:0] root_minus,
  output logic               overflow
);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // product stage
  logic               p_valid;
  logic signed [15:0] p_a;
  logic signed [15:0] p_b;
  logic signed [31:0] p_bb;
  logic signed [31:0] p_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
    end
    if (adv) begin
      p_a  <= coef_a;
      p_b  <= coef_b;
      p_bb <= coef_b * coef_b;
      p_ac <= coef_a * coef_c;
    end
  end

  // discriminant and classification
  logic signed [33:0] delta_w;
  logic               a_zero;
  logic signed [16:0] den_w;
  qrs_pkg::sq_t       sq_in;

  always_comb begin
    delta_w = {{2{p_bb[31]}}, p_bb} - {p_ac, 2'b00};
    a_zero  = p_a == 16'sd0;
    den_w   = {p_a, 1'b0};
    sq_in.valid   = p_valid;
    sq_in.status  = a_zero ? qrs_pkg::ST_NOT_QUAD :
                    delta_w[33] ? qrs_pkg::ST_NO_ROOTS :
                    (delta_w == 34'sd0) ? qrs_pkg::ST_ONE_ROOT : qrs_pkg::ST_TWO_ROOTS;
    sq_in.delta   = a_zero ? 34'd0 : delta_w;
    sq_in.neg_b   = -{{2{p_b[15]}}, p_b};
    sq_in.den_neg = den_w[16];
    sq_in.den_mag = den_w[16] ? -den_w : den_w;
    sq_in.rad     = (delta_w[33] || a_zero) ? 34'd0 : delta_w;
    sq_in.rem     = '0;
    sq_in.root    = '0;
  end

  qrs_pkg::sq_t sq_pipe [0:qrs_pkg::SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      sq_pipe[0].valid <= sq_in.valid;
    end
    if (adv) begin
      sq_pipe[0].status  <= sq_in.status;
      sq_pipe[0].delta   <= sq_in.delta;
      sq_pipe[0].neg_b   <= sq_in.neg_b;
      sq_pipe[0].den_neg <= sq_in.den_neg;
      sq_pipe[0].den_mag <= sq_in.den_mag;
      sq_pipe[0].rad     <= sq_in.rad;
      sq_pipe[0].rem     <= sq_in.rem;
      sq_pipe[0].root    <= sq_in.root;
    end
  end

  // square root pipeline
  genvar gi;
  generate
    for (gi = 0; gi < qrs_pkg::SQ_STAGES; gi++) begin : g_sq
      qrs_sqrt_stage u_sq (
        .clk(clk), .rst(rst), .en(adv), .d(sq_pipe[gi]), .q(sq_pipe[gi+1])
      );
    end
  endgenerate

  // numerators
  qrs_pkg::sq_t       sq_last;
  logic signed [17:0] num_p;
  logic signed [17:0] num_m;
  logic [17:0]        mag_p;
  logic [17:0]        mag_m;
  qrs_pkg::dv_t       dv_in;

  always_comb begin
    sq_last = sq_pipe[qrs_pkg::SQ_STAGES];
    num_p = sq_last.neg_b + $signed({1'b0, sq_last.root});
    num_m = sq_last.neg_b - $signed({1'b0, sq_last.root});
    mag_p = num_p[17] ? -num_p : num_p;
    mag_m = num_m[17] ? -num_m : num_m;
    dv_in.valid   = sq_last.valid;
    dv_in.status  = sq_last.status;
    dv_in.delta   = sq_last.delta;
    dv_in.den_neg = sq_last.den_neg;
    dv_in.den_mag = sq_last.den_mag;
    dv_in.p.neg   = num_p[17];
    dv_in.p.dvd   = {mag_p[16:0], 16'd0};
    dv_in.p.rem   = '0;
    dv_in.p.quo   = '0;
    dv_in.m.neg   = num_m[17];
    dv_in.m.dvd   = {mag_m[16:0], 16'd0};
    dv_in.m.rem   = '0;
    dv_in.m.quo   = '0;
  end

  qrs_pkg::dv_t dv_pipe [0:qrs_pkg::DV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      dv_pipe[0].valid <= dv_in.valid;
    end
    if (adv) begin
      dv_pipe[0].status  <= dv_in.status;
      dv_pipe[0].delta   <= dv_in.delta;
      dv_pipe[0].den_neg <= dv_in.den_neg;
      dv_pipe[0].den_mag <= dv_in.den_mag;
      dv_pipe[0].p       <= dv_in.p;
      dv_pipe[0].m       <= dv_in.m;
    end
  end

  // divide pipeline
  generate
    for (gi = 0; gi < qrs_pkg::DV_STAGES; gi++) begin : g_dv
      qrs_div_stage u_dv (
        .clk(clk), .rst(rst), .en(adv), .d(dv_pipe[gi]), .q(dv_pipe[gi+1])
      );
    end
  endgenerate

  // sign, saturation and result masking
  qrs_pkg::dv_t       dv_last;
  logic signed [31:0] q_p;
  logic signed [31:0] q_m;
  logic               sat_p;
  logic               sat_m;
  logic               roots_on;

  function automatic logic signed [31:0] sat_root(logic [32:0] mag, logic neg,
                                                  output logic sat);
    logic [32:0] negv;
    negv = -mag;
    sat  = 1'b0;
    if (!neg) begin
      if (mag[32] || mag[31]) begin
        sat = 1'b1;
        return qrs_pkg::ROOT_MAX;
      end
      return mag[31:0];
    end
    if (mag > 33'h0_8000_0000) begin
      sat = 1'b1;
      return qrs_pkg::ROOT_MIN;
    end
    return negv[31:0];
  endfunction

  always_comb begin
    dv_last  = dv_pipe[qrs_pkg::DV_STAGES];
    q_p      = sat_root(dv_last.p.quo, dv_last.p.neg ^ dv_last.den_neg, sat_p);
    q_m      = sat_root(dv_last.m.quo, dv_last.m.neg ^ dv_last.den_neg, sat_m);
    roots_on = dv_last.status == qrs_pkg::ST_ONE_ROOT
            || dv_last.status == qrs_pkg::ST_TWO_ROOTS;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_last.valid;
    end
    if (adv) begin
      status       <= dv_last.status;
      discriminant <= dv_last.delta;
      root_plus    <= roots_on ? q_p : 32'sd0;
      root_minus   <= roots_on ? q_m : 32'sd0;
      overflow     <= roots_on && (sat_p || sat_m);
    end
  end

  // not quadratic gives all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qrs_pkg::ST_NOT_QUAD |->
      discriminant == 34'sd0 && root_plus == 32'sd0 && root_minus == 32'sd0 && !overflow)
    else $error("not-quadratic result carries nonzero fields");

  // no real roots leaves the roots clear and the discriminant negative
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qrs_pkg::ST_NO_ROOTS |->
      discriminant[33] && root_plus == 32'sd0 && root_minus == 32'sd0 && !overflow)
    else $error("no-roots result inconsistent");

  // a single root appears in both root fields with a zero discriminant
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qrs_pkg::ST_ONE_ROOT |->
      root_plus == root_minus && discriminant == 34'sd0)
    else $error("one-root result inconsistent");

  // two roots come from a positive discriminant
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qrs_pkg::ST_TWO_ROOTS |->
      !discriminant[33] && discriminant != 34'sd0)
    else $error("two-root result without positive discriminant");

endmodule

`default_nettype wire

FILE: design/qrs_sqrt_stage.sv
// one registered step of the digit-by-digit integer square root
// depends on qrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt_stage (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire qrs_pkg::sq_t d,
  output qrs_pkg::sq_t      q
);

  logic [21:0] rem4;
  logic [21:0] trial;
  logic        ge;
  logic [21:0] diff;
  qrs_pkg::sq_t nxt;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem4  = {d.rem, d.rad[33:32]};
    trial = {3'b000, d.root, 2'b01};
    ge    = rem4 >= trial;
    diff  = rem4 - trial;
    nxt = d;
    nxt.rem  = ge ? diff[19:0] : rem4[19:0];
    nxt.root = {d.root[15:0], ge};
    nxt.rad  = {d.rad[31:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.status  <= nxt.status;
      q.delta   <= nxt.delta;
      q.neg_b   <= nxt.neg_b;
      q.den_neg <= nxt.den_neg;
      q.den_mag <= nxt.den_mag;
      q.rad     <= nxt.rad;
      q.rem     <= nxt.rem;
      q.root    <= nxt.root;
    end
  end

endmodule

`default_nettype wire

FILE: design/qrs_div_stage.sv
// one registered restoring division step for both root lanes
// depends on qrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_stage (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire qrs_pkg::dv_t d,
  output qrs_pkg::dv_t      q
);

  function automatic qrs_pkg::lane_t step(qrs_pkg::lane_t l, logic [16:0] den);
    logic [17:0] rem2;
    logic [17:0] diff;
    logic        ge;
    qrs_pkg::lane_t r;
    rem2 = {l.rem, l.dvd[32]};
    diff = rem2 - {1'b0, den};
    ge   = rem2 >= {1'b0, den};
    r     = l;
    r.rem = ge ? diff[16:0] : rem2[16:0];
    r.quo = {l.quo[31:0], ge};
    r.dvd = {l.dvd[31:0], 1'b0};
    return r;
  endfunction

  qrs_pkg::dv_t nxt;

  // one quotient bit per lane
  always_comb begin
    nxt = d;
    nxt.p = step(d.p, d.den_mag);
    nxt.m = step(d.m, d.den_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.status  <= nxt.status;
      q.delta   <= nxt.delta;
      q.den_neg <= nxt.den_neg;
      q.den_mag <= nxt.den_mag;
      q.p       <= nxt.p;
      q.m       <= nxt.m;
    end
  end

endmodule

`default_nettype wire
